@@ rtl/abcg_pkg.sv @@
// Shared types, constants and register indexes for the animated border color generator.
`default_nettype none

package abcg_pkg;

  localparam int COORD_BITS  = 16;
  localparam int PHASE_CYCLE = 10000;
  localparam int PH_W        = $clog2(PHASE_CYCLE);

  localparam int TIME_W   = 32;
  localparam int SPEED_W  = 16;
  localparam int THICK_W  = 8;
  localparam int SCREEN_W = 15;
  localparam int COLOR_W  = 32;

  localparam int PROD_W = TIME_W + SPEED_W;
  localparam int STEP_W = PROD_W - 8;
  localparam int SUM_W  = STEP_W + 1;

  localparam int HUE_W    = 11;
  localparam int XQ_W     = PH_W + 2;
  localparam int RECIP_K  = XQ_W + 9 + PH_W;
  localparam int RECIP_W  = RECIP_K - PH_W + 2;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_K) + 64'(PHASE_CYCLE) - 64'd1) / 64'(PHASE_CYCLE);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  localparam int CMP_W = ((COORD_BITS > SCREEN_W) ? COORD_BITS : SCREEN_W) + 1;

  localparam logic [7:0] PULSE_MAX = 8'd175;
  localparam logic [7:0] ALPHA     = 8'hFF;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THICK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_W   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_H   = 3'd4;

  localparam logic                RST_PALETTE = 1'b0;
  localparam logic [SPEED_W-1:0]  RST_SPEED   = 16'd2048;
  localparam logic [THICK_W-1:0]  RST_THICK   = 8'd3;
  localparam logic [SCREEN_W-1:0] RST_SCR_W   = 15'd1024;
  localparam logic [SCREEN_W-1:0] RST_SCR_H   = 15'd768;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                palette;
    logic [SPEED_W-1:0]  speed;
    logic [THICK_W-1:0]  thick;
    logic [SCREEN_W-1:0] scr_w;
    logic [SCREEN_W-1:0] scr_h;
  } cfg_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    coord_t cl;
    coord_t ct;
    coord_t cr;
    coord_t cb;
  } geom_t;

  typedef struct packed {
    coord_t               x1;
    coord_t               y1;
    coord_t               x2;
    coord_t               y2;
    coord_t               x1h;
    coord_t               x2h;
    coord_t               y1v;
    coord_t               y2v;
    logic [COLOR_W-1:0]   color;
    coord_t               cl;
    coord_t               ct;
    coord_t               cr;
    coord_t               cb;
  } frame_t;

  typedef enum logic [1:0] {
    PIECE_LEFT,
    PIECE_TOP,
    PIECE_BOTTOM,
    PIECE_RIGHT
  } piece_t;

endpackage

`default_nettype wire

@@ rtl/abcg_if.sv @@
// Channel interfaces: frame input, border piece output and register write port.
`default_nettype none

interface abcg_in_if;
  import abcg_pkg::*;
  logic                valid;
  logic                ready;
  logic                active;
  logic [TIME_W-1:0]   game_time;
  coord_t              win_left;
  coord_t              win_top;
  coord_t              win_right;
  coord_t              win_bottom;
  coord_t              clip_left;
  coord_t              clip_top;
  coord_t              clip_rgt;
  coord_t              clip_btm;

  modport source(output valid, active, game_time, win_left, win_top, win_right,
                 win_bottom, clip_left, clip_top, clip_rgt, clip_btm,
                 input ready);
  modport sink(input valid, active, game_time, win_left, win_top, win_right,
               win_bottom, clip_left, clip_top, clip_rgt, clip_btm,
               output ready);
endinterface

interface abcg_out_if;
  import abcg_pkg::*;
  logic                valid;
  logic                ready;
  coord_t              rect_left;
  coord_t              rect_top;
  coord_t              rect_right;
  coord_t              rect_bottom;
  logic [COLOR_W-1:0]  color;
  coord_t              out_clip_left;
  coord_t              out_clip_top;
  coord_t              out_clip_rgt;
  coord_t              out_clip_btm;
  logic                last_rect;

  modport source(output valid, rect_left, rect_top, rect_right, rect_bottom, color,
                 out_clip_left, out_clip_top, out_clip_rgt, out_clip_btm,
                 last_rect, input ready);
  modport sink(input valid, rect_left, rect_top, rect_right, rect_bottom, color,
               out_clip_left, out_clip_top, out_clip_rgt, out_clip_btm,
               last_rect, output ready);
endinterface

interface abcg_cfg_if;
  import abcg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/animated_border_color_generator_top.sv @@
// Top level of the animated border color generator with its register file.
`default_nettype none

// Each input word is one frame. An inactive frame clears the color phase and
// produces nothing; an active frame produces four border rectangle words in the
// order left, top, bottom, right, all carrying the same ARGB color and clip
// rectangle, with last_rect set on the fourth. A frame passes a five-stage
// front pipeline (time delta, speed multiply, phase update, reciprocal
// multiply for the hue index, color lookup) and waits in a two-entry queue;
// the emitter then sends one rectangle per cycle while the output is ready.
// Inactive frames are accepted at one per cycle while the front pipeline is
// not stalled by a full queue. Register writes are always accepted and take
// effect on the next cycle; write them only while idle.
module animated_border_color_generator_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  abcg_in_if.sink    in_chan,
  abcg_out_if.source out_chan,
  abcg_cfg_if.sink   cfg_chan
);
  import abcg_pkg::*;

  cfg_t    cfg_r;
  logic    q_full;
  logic    q_push;
  frame_t  q_data;
  logic    q_pop;
  logic    head_valid;
  frame_t  head;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.palette <= RST_PALETTE;
      cfg_r.speed   <= RST_SPEED;
      cfg_r.thick   <= RST_THICK;
      cfg_r.scr_w   <= RST_SCR_W;
      cfg_r.scr_h   <= RST_SCR_H;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_PALETTE: cfg_r.palette <= cfg_chan.data[0];
        CFG_SPEED:   cfg_r.speed   <= cfg_chan.data[SPEED_W-1:0];
        CFG_THICK:   cfg_r.thick   <= cfg_chan.data[THICK_W-1:0];
        CFG_SCR_W:   cfg_r.scr_w   <= cfg_chan.data[SCREEN_W-1:0];
        CFG_SCR_H:   cfg_r.scr_h   <= cfg_chan.data[SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  abcg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  abcg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  abcg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (q_pop),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire

@@ rtl/abcg_front.sv @@
// Front pipeline: phase tracking, color lookup and border geometry per frame.
`default_nettype none

module abcg_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire abcg_pkg::cfg_t  cfg,
  abcg_in_if.sink              in_chan,
  input  wire logic            q_full,
  output logic                 q_push,
  output abcg_pkg::frame_t     q_data
);
  import abcg_pkg::*;

  logic                    adv;
  logic                    acc;

  logic [TIME_W-1:0]       last_time_r;
  logic                    seen_r;
  logic [PH_W-1:0]         phase_r;

  logic                    v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                    act1_r, act2_r, act3_r, act4_r, act5_r;

  logic [TIME_W-1:0]       delta_c;
  logic [TIME_W-1:0]       delta1_r;
  geom_t                   geom_c;
  geom_t                   geom1_r;

  logic [PROD_W-1:0]       prod2_r;
  geom_t                   geom2_r;
  logic [THICK_W-1:0]      ht2_r;
  logic [THICK_W-1:0]      vt2_r;
  logic [COORD_BITS:0]     dx_c;
  logic [COORD_BITS:0]     dy_c;
  logic [COORD_BITS-1:0]   thick_ext;

  logic [SUM_W-1:0]        sum_c;
  logic [XQ_W-1:0]         xq_c;
  logic [XQ_W-1:0]         xq3_r;
  frame_t                  fr3_r;

  logic [XQ_W+RECIP_W-1:0] recip_prod;
  logic [HUE_W-1:0]        n4_r;
  frame_t                  fr4_r;

  logic [7:0]              ofs;
  logic [2:0]              region;
  logic [15:0]             s_prod;
  logic [7:0]              s_val;
  logic [7:0]              s_inv;
  logic [COLOR_W-1:0]      color_c;
  frame_t                  fr5_nxt;
  frame_t                  fr5_r;

  logic signed [CMP_W-1:0] cr_wide;
  logic signed [CMP_W-1:0] cb_wide;
  logic signed [CMP_W-1:0] sw_wide;
  logic signed [CMP_W-1:0] sh_wide;

  assign adv           = !(v5_r && act5_r && q_full);
  assign in_chan.ready = adv;
  assign acc           = in_chan.valid && adv;
  assign q_push        = adv && v5_r && act5_r;
  assign q_data        = fr5_r;

  // sample stage: time delta, corner sort, clip limits
  always_comb begin
    delta_c = seen_r ? (in_chan.game_time - last_time_r) : '0;

    geom_c.x1 = (in_chan.win_left > in_chan.win_right) ? in_chan.win_right : in_chan.win_left;
    geom_c.x2 = (in_chan.win_left > in_chan.win_right) ? in_chan.win_left : in_chan.win_right;
    geom_c.y1 = (in_chan.win_top > in_chan.win_bottom) ? in_chan.win_bottom : in_chan.win_top;
    geom_c.y2 = (in_chan.win_top > in_chan.win_bottom) ? in_chan.win_top : in_chan.win_bottom;
    geom_c.cl = in_chan.clip_left;
    geom_c.ct = in_chan.clip_top;

    cr_wide = CMP_W'(in_chan.clip_rgt);
    cb_wide = CMP_W'(in_chan.clip_btm);
    sw_wide = signed'({{(CMP_W-SCREEN_W){1'b0}}, cfg.scr_w});
    sh_wide = signed'({{(CMP_W-SCREEN_W){1'b0}}, cfg.scr_h});
    geom_c.cr = (cr_wide > sw_wide) ? coord_t'(sw_wide[COORD_BITS-1:0]) : in_chan.clip_rgt;
    geom_c.cb = (cb_wide > sh_wide) ? coord_t'(sh_wide[COORD_BITS-1:0]) : in_chan.clip_btm;
  end

  // thickness stage: half extent limited by the configured thickness
  always_comb begin
    thick_ext = COORD_BITS'(cfg.thick);
    dx_c = {geom1_r.x2[COORD_BITS-1], geom1_r.x2} - {geom1_r.x1[COORD_BITS-1], geom1_r.x1};
    dy_c = {geom1_r.y2[COORD_BITS-1], geom1_r.y2} - {geom1_r.y1[COORD_BITS-1], geom1_r.y1};
  end

  // phase stage: advance, restart from zero on reaching the cycle length
  always_comb begin
    sum_c = SUM_W'(phase_r) + SUM_W'(prod2_r[PROD_W-1:8]);
    xq_c  = cfg.palette ? (XQ_W'(phase_r) + XQ_W'({phase_r, 1'b0})) : XQ_W'(phase_r);
  end

  assign recip_prod = xq3_r * RECIP;

  // color stage
  always_comb begin
    ofs     = n4_r[7:0];
    region  = n4_r[HUE_W-1:8];
    s_prod  = 16'(ofs) * 16'(PULSE_MAX);
    s_val   = s_prod[15:8];
    s_inv   = PULSE_MAX - s_val;
    color_c = {ALPHA, 24'h000000};
    if (cfg.palette) begin
      case (region)
        3'd0:    color_c = {ALPHA, 8'hFF, ofs, 8'h00};
        3'd1:    color_c = {ALPHA, 8'hFF - ofs, 8'hFF, 8'h00};
        3'd2:    color_c = {ALPHA, 8'h00, 8'hFF, ofs};
        3'd3:    color_c = {ALPHA, 8'h00, 8'hFF - ofs, 8'hFF};
        3'd4:    color_c = {ALPHA, ofs, 8'h00, 8'hFF};
        3'd5:    color_c = {ALPHA, 8'hFF, 8'h00, 8'hFF - ofs};
        default: color_c = {ALPHA, 24'h000000};
      endcase
    end else begin
      case (region)
        3'd0:    color_c = {ALPHA, 8'hFF, s_val, s_val};
        3'd1:    color_c = {ALPHA, 8'hFF, s_inv, s_inv};
        default: color_c = {ALPHA, 24'h000000};
      endcase
    end
  end

  always_comb begin
    fr5_nxt       = fr4_r;
    fr5_nxt.color = color_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      seen_r      <= 1'b0;
      last_time_r <= '0;
      phase_r     <= '0;
    end else begin
      if (adv) begin
        v1_r <= in_chan.valid;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
        v5_r <= v4_r;
      end
      if (acc && in_chan.active) begin
        seen_r      <= 1'b1;
        last_time_r <= in_chan.game_time;
      end
      if (adv && v2_r) begin
        if (!act2_r || (sum_c >= SUM_W'(PHASE_CYCLE))) begin
          phase_r <= '0;
        end else begin
          phase_r <= sum_c[PH_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act1_r   <= in_chan.active;
      delta1_r <= delta_c;
      geom1_r  <= geom_c;

      act2_r  <= act1_r;
      prod2_r <= delta1_r * cfg.speed;
      geom2_r <= geom1_r;
      ht2_r   <= (dx_c[COORD_BITS:1] > thick_ext) ? cfg.thick : dx_c[THICK_W:1];
      vt2_r   <= (dy_c[COORD_BITS:1] > thick_ext) ? cfg.thick : dy_c[THICK_W:1];

      act3_r       <= act2_r;
      xq3_r        <= xq_c;
      fr3_r.x1     <= geom2_r.x1;
      fr3_r.y1     <= geom2_r.y1;
      fr3_r.x2     <= geom2_r.x2;
      fr3_r.y2     <= geom2_r.y2;
      fr3_r.x1h    <= geom2_r.x1 + coord_t'(ht2_r);
      fr3_r.x2h    <= geom2_r.x2 - coord_t'(ht2_r);
      fr3_r.y1v    <= geom2_r.y1 + coord_t'(vt2_r);
      fr3_r.y2v    <= geom2_r.y2 - coord_t'(vt2_r);
      fr3_r.color  <= '0;
      fr3_r.cl     <= geom2_r.cl;
      fr3_r.ct     <= geom2_r.ct;
      fr3_r.cr     <= geom2_r.cr;
      fr3_r.cb     <= geom2_r.cb;

      act4_r <= act3_r;
      n4_r   <= recip_prod[RECIP_K-9 +: HUE_W];
      fr4_r  <= fr3_r;

      act5_r <= act4_r;
      fr5_r  <= fr5_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/abcg_queue.sv @@
// Two-entry frame queue between the front pipeline and the piece emitter.
`default_nettype none

module abcg_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire abcg_pkg::frame_t  push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output abcg_pkg::frame_t       head
);
  import abcg_pkg::*;

  frame_t      entry_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/abcg_back.sv @@
// Piece emitter: splits each queued frame into four border rectangles.
`default_nettype none

module abcg_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire abcg_pkg::frame_t  head,
  input  wire logic              head_valid,
  output logic                   pop,
  abcg_out_if.source             out_chan
);
  import abcg_pkg::*;

  piece_t              piece_r;
  logic                out_valid_r;
  logic                load;
  coord_t              left_c, top_c, right_c, bottom_c;
  coord_t              left_r, top_r, right_r, bottom_r;
  logic [COLOR_W-1:0]  color_r;
  coord_t              cl_r, ct_r, cr_r, cb_r;
  logic                last_r;

  assign load = head_valid && (!out_valid_r || out_chan.ready);
  assign pop  = load && (piece_r == PIECE_RIGHT);

  always_comb begin
    case (piece_r)
      PIECE_LEFT: begin
        left_c   = head.x1;
        top_c    = head.y1;
        right_c  = head.x1h;
        bottom_c = head.y2;
      end
      PIECE_TOP: begin
        left_c   = head.x1h;
        top_c    = head.y1;
        right_c  = head.x2h;
        bottom_c = head.y1v;
      end
      PIECE_BOTTOM: begin
        left_c   = head.x1h;
        top_c    = head.y2v;
        right_c  = head.x2h;
        bottom_c = head.y2;
      end
      default: begin
        left_c   = head.x2h;
        top_c    = head.y1;
        right_c  = head.x2;
        bottom_c = head.y2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piece_r     <= PIECE_LEFT;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        piece_r     <= piece_t'(piece_r + 2'd1);
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r   <= left_c;
      top_r    <= top_c;
      right_r  <= right_c;
      bottom_r <= bottom_c;
      color_r  <= head.color;
      cl_r     <= head.cl;
      ct_r     <= head.ct;
      cr_r     <= head.cr;
      cb_r     <= head.cb;
      last_r   <= (piece_r == PIECE_RIGHT);
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.rect_left     = left_r;
  assign out_chan.rect_top      = top_r;
  assign out_chan.rect_right    = right_r;
  assign out_chan.rect_bottom   = bottom_r;
  assign out_chan.color         = color_r;
  assign out_chan.out_clip_left = cl_r;
  assign out_chan.out_clip_top  = ct_r;
  assign out_chan.out_clip_rgt  = cr_r;
  assign out_chan.out_clip_btm  = cb_r;
  assign out_chan.last_rect     = last_r;

endmodule

`default_nettype wire
